// ===== hw/rtl/cft_pkg.sv =====
package cft_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int IN_BITS    = 12;
  localparam int OUT_BITS   = 24;

  // widths of the intermediate terms
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DET_W  = PROD_W + 2;
  localparam int NORM_W = 2 * COORD_BITS + 1;
  localparam int NUM_W  = DIFF_W + NORM_W + 2;
  localparam int DIVD_W = NUM_W + FRAC_BITS;
  localparam int DEN_W  = DET_W;
  localparam int QB     = ((OUT_BITS > COORD_BITS + FRAC_BITS) ?
                           OUT_BITS : COORD_BITS + FRAC_BITS) + 2;
  localparam int REM_W  = (DIVD_W > DEN_W + QB) ? DIVD_W : DEN_W + QB;
  localparam int DX_W   = QB + 2;
  localparam int CS_W   = ((DX_W > COORD_BITS + FRAC_BITS + 1) ?
                           DX_W : COORD_BITS + FRAC_BITS + 1) + 1;
  localparam int SQ_W   = 2 * OUT_BITS + 1;
  localparam int RB     = OUT_BITS + 1;
  localparam int SR_W   = SQ_W + 1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   deg;
    coord_t x1;
    coord_t y1;
    logic   neg_x;
    logic   neg_y;
    logic   big_x;
    logic   big_y;
  } div_side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [REM_W-1:0] dsh;
    logic [QB-1:0]    q_x;
    logic [QB-1:0]    q_y;
    div_side_t        side;
  } div_data_t;

  typedef struct packed {
    logic                       deg;
    logic                       sat;
    logic                       rad_big;
    logic signed [OUT_BITS-1:0] cx;
    logic signed [OUT_BITS-1:0] cy;
  } sqrt_side_t;

  typedef struct packed {
    logic [SR_W-1:0] v;
    logic [SR_W-1:0] res;
    logic [SR_W-1:0] probe;
    sqrt_side_t      side;
  } sqrt_data_t;

endpackage

// ===== hw/rtl/cft_if.sv =====
interface cft_in_if;
  logic                         valid;
  logic                         ready;
  logic [cft_pkg::IN_BITS-1:0]  first_x;
  logic [cft_pkg::IN_BITS-1:0]  first_y;
  logic [cft_pkg::IN_BITS-1:0]  second_x;
  logic [cft_pkg::IN_BITS-1:0]  second_y;
  logic [cft_pkg::IN_BITS-1:0]  third_x;
  logic [cft_pkg::IN_BITS-1:0]  third_y;

  modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                  input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                output ready);
endinterface

interface cft_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cft_pkg::OUT_BITS-1:0] center_x;
  logic signed [cft_pkg::OUT_BITS-1:0] center_y;
  logic [cft_pkg::OUT_BITS-1:0]        radius;
  logic                                degenerate;
  logic                                saturated;

  modport source (output valid, center_x, center_y, radius, degenerate, saturated,
                  input ready);
  modport sink (input valid, center_x, center_y, radius, degenerate, saturated,
                output ready);
endinterface

// ===== hw/rtl/cft_div_cell.sv =====
module cft_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cft_pkg::div_data_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cft_pkg::div_data_t out_data
);

  logic               valid_r;
  cft_pkg::div_data_t data_r;
  cft_pkg::div_data_t data_nxt;
  logic               ge_x;
  logic               ge_y;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // one restoring quotient bit per lane
  always_comb begin
    ge_x           = in_data.rem_x >= in_data.dsh;
    ge_y           = in_data.rem_y >= in_data.dsh;
    data_nxt       = in_data;
    data_nxt.rem_x = ge_x ? in_data.rem_x - in_data.dsh : in_data.rem_x;
    data_nxt.rem_y = ge_y ? in_data.rem_y - in_data.dsh : in_data.rem_y;
    data_nxt.q_x   = {in_data.q_x[cft_pkg::QB-2:0], ge_x};
    data_nxt.q_y   = {in_data.q_y[cft_pkg::QB-2:0], ge_y};
    data_nxt.dsh   = in_data.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hw/rtl/cft_sqrt_cell.sv =====
module cft_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cft_pkg::sqrt_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cft_pkg::sqrt_data_t out_data
);

  logic                        valid_r;
  cft_pkg::sqrt_data_t         data_r;
  cft_pkg::sqrt_data_t         data_nxt;
  logic [cft_pkg::SR_W-1:0]    trial;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // one root bit
  always_comb begin
    trial    = in_data.res + in_data.probe;
    data_nxt = in_data;
    if (in_data.v >= trial) begin
      data_nxt.v   = in_data.v - trial;
      data_nxt.res = (in_data.res >> 1) + in_data.probe;
    end else begin
      data_nxt.res = in_data.res >> 1;
    end
    data_nxt.probe = in_data.probe >> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hw/rtl/circle_from_three_points.sv =====
// circle through three pixel points: centre and radius in fixed point with
// FRAC_BITS fraction bits. fully pipelined, one item accepted per clock when
// the result side keeps up; an item passes the offset, determinant, numerator
// and sign stages, the bit-per-cell restoring divider chain (QB cells, both
// centre offsets side by side), the offset, clipping and square stages, the
// bit-per-cell square root chain (RB cells) and the output register. every
// stage has its own valid bit and ready, so bubbles close up and a new item
// is taken while a finished result waits at the output. collinear or coincident
// points give zero fields with degenerate set; clipped fields raise saturated.
module circle_from_three_points (
  input  logic clk,
  input  logic rst_n,
  cft_in_if.sink    in_ch,
  cft_out_if.source out_ch
);

  localparam int DIFF_W   = cft_pkg::DIFF_W;
  localparam int DET_W    = cft_pkg::DET_W;
  localparam int NORM_W   = cft_pkg::NORM_W;
  localparam int PROD_W   = cft_pkg::PROD_W;
  localparam int NUM_W    = cft_pkg::NUM_W;
  localparam int DEN_W    = cft_pkg::DEN_W;
  localparam int REM_W    = cft_pkg::REM_W;
  localparam int QB       = cft_pkg::QB;
  localparam int DX_W     = cft_pkg::DX_W;
  localparam int CS_W     = cft_pkg::CS_W;
  localparam int OUT_BITS = cft_pkg::OUT_BITS;
  localparam int SQ_W     = cft_pkg::SQ_W;
  localparam int SR_W     = cft_pkg::SR_W;
  localparam int RB       = cft_pkg::RB;
  localparam int CB       = cft_pkg::COORD_BITS;
  localparam int FB       = cft_pkg::FRAC_BITS;

  localparam logic signed [CS_W-1:0] CEN_MAX = (CS_W'(1) <<< (OUT_BITS - 1)) - CS_W'(1);
  localparam logic signed [CS_W-1:0] CEN_MIN = -(CS_W'(1) <<< (OUT_BITS - 1));
  localparam logic signed [DX_W-1:0] DX_LIM  = DX_W'(1) <<< OUT_BITS;

  // ---------------- stage 1: offsets from the first point
  logic                     s1_v_r;
  logic                     s1_rdy;
  cft_pkg::coord_t          s1_x1_r, s1_y1_r;
  logic signed [DIFF_W-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic                     s2_rdy;

  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_ch.valid) begin
      s1_x1_r <= in_ch.first_x[CB-1:0];
      s1_y1_r <= in_ch.first_y[CB-1:0];
      s1_ax_r <= $signed({1'b0, in_ch.second_x[CB-1:0]}) - $signed({1'b0, in_ch.first_x[CB-1:0]});
      s1_ay_r <= $signed({1'b0, in_ch.second_y[CB-1:0]}) - $signed({1'b0, in_ch.first_y[CB-1:0]});
      s1_bx_r <= $signed({1'b0, in_ch.third_x[CB-1:0]}) - $signed({1'b0, in_ch.first_x[CB-1:0]});
      s1_by_r <= $signed({1'b0, in_ch.third_y[CB-1:0]}) - $signed({1'b0, in_ch.first_y[CB-1:0]});
    end
  end

  // ---------------- stage 2: determinant and squared lengths
  logic                     s2_v_r;
  cft_pkg::coord_t          s2_x1_r, s2_y1_r;
  logic signed [DIFF_W-1:0] s2_ax_r, s2_ay_r, s2_bx_r, s2_by_r;
  logic signed [DET_W-1:0]  s2_d_r;
  logic [NORM_W-1:0]        s2_na_r, s2_nb_r;
  logic signed [DET_W-1:0]  d_nxt;
  logic signed [PROD_W:0]   na_sum, nb_sum;
  logic                     s3_rdy;

  assign s2_rdy = !s2_v_r || s3_rdy;

  always_comb begin
    d_nxt  = (DET_W'(s1_ax_r) * DET_W'(s1_by_r) - DET_W'(s1_ay_r) * DET_W'(s1_bx_r)) <<< 1;
    na_sum = (PROD_W + 1)'(s1_ax_r) * (PROD_W + 1)'(s1_ax_r)
           + (PROD_W + 1)'(s1_ay_r) * (PROD_W + 1)'(s1_ay_r);
    nb_sum = (PROD_W + 1)'(s1_bx_r) * (PROD_W + 1)'(s1_bx_r)
           + (PROD_W + 1)'(s1_by_r) * (PROD_W + 1)'(s1_by_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_x1_r <= s1_x1_r;
      s2_y1_r <= s1_y1_r;
      s2_ax_r <= s1_ax_r;
      s2_ay_r <= s1_ay_r;
      s2_bx_r <= s1_bx_r;
      s2_by_r <= s1_by_r;
      s2_d_r  <= d_nxt;
      s2_na_r <= na_sum[NORM_W-1:0];
      s2_nb_r <= nb_sum[NORM_W-1:0];
    end
  end

  // ---------------- stage 3: numerators of the centre offsets
  logic                    s3_v_r;
  cft_pkg::coord_t         s3_x1_r, s3_y1_r;
  logic signed [DET_W-1:0] s3_d_r;
  logic signed [NUM_W-1:0] s3_nx_r, s3_ny_r;
  logic signed [NUM_W-1:0] na_s, nb_s;
  logic                    s4_rdy;

  assign s3_rdy = !s3_v_r || s4_rdy;
  assign na_s   = NUM_W'($signed({1'b0, s2_na_r}));
  assign nb_s   = NUM_W'($signed({1'b0, s2_nb_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_x1_r <= s2_x1_r;
      s3_y1_r <= s2_y1_r;
      s3_d_r  <= s2_d_r;
      s3_nx_r <= NUM_W'(s2_by_r) * na_s - NUM_W'(s2_ay_r) * nb_s;
      s3_ny_r <= NUM_W'(s2_ax_r) * nb_s - NUM_W'(s2_bx_r) * na_s;
    end
  end

  // ---------------- stage 4: magnitudes and signs for the divider
  logic             s4_v_r;
  cft_pkg::coord_t  s4_x1_r, s4_y1_r;
  logic [NUM_W-1:0] s4_mx_r, s4_my_r;
  logic [DEN_W-1:0] s4_den_r;
  logic             s4_negx_r, s4_negy_r, s4_deg_r;
  logic             div_rdy [QB+1];
  logic             div_v   [QB+1];
  cft_pkg::div_data_t div_d [QB+1];

  assign s4_rdy = !s4_v_r || div_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_r <= s3_v_r;
    end
  end

  // the offset sign is the numerator sign flipped when the determinant is negative
  always_ff @(posedge clk) begin
    if (s4_rdy && s3_v_r) begin
      s4_x1_r   <= s3_x1_r;
      s4_y1_r   <= s3_y1_r;
      s4_mx_r   <= s3_nx_r[NUM_W-1] ? NUM_W'(-s3_nx_r) : NUM_W'(s3_nx_r);
      s4_my_r   <= s3_ny_r[NUM_W-1] ? NUM_W'(-s3_ny_r) : NUM_W'(s3_ny_r);
      s4_den_r  <= s3_d_r[DET_W-1] ? DEN_W'(-s3_d_r) : DEN_W'(s3_d_r);
      s4_negx_r <= s3_nx_r[NUM_W-1] ^ s3_d_r[DET_W-1];
      s4_negy_r <= s3_ny_r[NUM_W-1] ^ s3_d_r[DET_W-1];
      s4_deg_r  <= s3_d_r == '0;
    end
  end

  // divider entry: scaled dividend, quotient range check, aligned divisor
  logic [REM_W-1:0] divd_x, divd_y, den_top;

  always_comb begin
    divd_x  = REM_W'(s4_mx_r) << FB;
    divd_y  = REM_W'(s4_my_r) << FB;
    den_top = REM_W'(s4_den_r) << QB;
    div_v[0]              = s4_v_r;
    div_d[0].rem_x        = divd_x;
    div_d[0].rem_y        = divd_y;
    div_d[0].dsh          = REM_W'(s4_den_r) << (QB - 1);
    div_d[0].q_x          = '0;
    div_d[0].q_y          = '0;
    div_d[0].side.deg     = s4_deg_r;
    div_d[0].side.x1      = s4_x1_r;
    div_d[0].side.y1      = s4_y1_r;
    div_d[0].side.neg_x   = s4_negx_r;
    div_d[0].side.neg_y   = s4_negy_r;
    div_d[0].side.big_x   = divd_x >= den_top;
    div_d[0].side.big_y   = divd_y >= den_top;
  end

  // ---------------- divider chain, one quotient bit per cell
  for (genvar i = 0; i < QB; i++) begin : g_div
    cft_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[i]),
      .in_ready  (div_rdy[i]),
      .in_data   (div_d[i]),
      .out_valid (div_v[i+1]),
      .out_ready (div_rdy[i+1]),
      .out_data  (div_d[i+1])
    );
  end

  // ---------------- stage 5: floored signed offsets
  logic                   s5_v_r;
  logic                   s5_rdy;
  cft_pkg::div_side_t     s5_side_r;
  logic signed [DX_W-1:0] s5_dx_r, s5_dy_r;
  logic signed [DX_W-1:0] qx_s, qy_s;
  logic                   s6_rdy;

  assign s5_rdy      = !s5_v_r || s6_rdy;
  assign div_rdy[QB] = s5_rdy;
  assign qx_s        = DX_W'($signed({1'b0, div_d[QB].q_x}));
  assign qy_s        = DX_W'($signed({1'b0, div_d[QB].q_y}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (s5_rdy) begin
      s5_v_r <= div_v[QB];
    end
  end

  // negative offsets round away from zero when the remainder is left over
  always_ff @(posedge clk) begin
    if (s5_rdy && div_v[QB]) begin
      s5_side_r <= div_d[QB].side;
      s5_dx_r   <= div_d[QB].side.neg_x ?
                   -(qx_s + DX_W'(div_d[QB].rem_x != '0)) : qx_s;
      s5_dy_r   <= div_d[QB].side.neg_y ?
                   -(qy_s + DX_W'(div_d[QB].rem_y != '0)) : qy_s;
    end
  end

  // ---------------- stage 6: centre clipping, radius range
  logic                       s6_v_r;
  cft_pkg::sqrt_side_t        s6_side_r;
  logic [OUT_BITS-1:0]        s6_adx_r, s6_ady_r;
  logic signed [CS_W-1:0]     cs_x, cs_y;
  logic signed [CS_W-1:0]     cl_x, cl_y;
  logic                       sat_x, sat_y, rbig;
  logic signed [DX_W-1:0]     adx_w, ady_w;
  logic                       s7_rdy;

  assign s6_rdy = !s6_v_r || s7_rdy;

  always_comb begin
    cs_x = (CS_W'($signed({1'b0, s5_side_r.x1})) <<< FB) + CS_W'(s5_dx_r);
    cs_y = (CS_W'($signed({1'b0, s5_side_r.y1})) <<< FB) + CS_W'(s5_dy_r);
    sat_x = 1'b1;
    sat_y = 1'b1;
    if (s5_side_r.big_x) begin
      cl_x = s5_side_r.neg_x ? CEN_MIN : CEN_MAX;
    end else if (cs_x > CEN_MAX) begin
      cl_x = CEN_MAX;
    end else if (cs_x < CEN_MIN) begin
      cl_x = CEN_MIN;
    end else begin
      cl_x  = cs_x;
      sat_x = 1'b0;
    end
    if (s5_side_r.big_y) begin
      cl_y = s5_side_r.neg_y ? CEN_MIN : CEN_MAX;
    end else if (cs_y > CEN_MAX) begin
      cl_y = CEN_MAX;
    end else if (cs_y < CEN_MIN) begin
      cl_y = CEN_MIN;
    end else begin
      cl_y  = cs_y;
      sat_y = 1'b0;
    end
    rbig = s5_side_r.big_x || s5_side_r.big_y ||
           s5_dx_r >= DX_LIM || s5_dx_r <= -DX_LIM ||
           s5_dy_r >= DX_LIM || s5_dy_r <= -DX_LIM;
    adx_w = s5_dx_r[DX_W-1] ? -s5_dx_r : s5_dx_r;
    ady_w = s5_dy_r[DX_W-1] ? -s5_dy_r : s5_dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (s6_rdy) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_rdy && s5_v_r) begin
      s6_side_r.deg     <= s5_side_r.deg;
      s6_side_r.sat     <= sat_x || sat_y || rbig;
      s6_side_r.rad_big <= rbig;
      s6_side_r.cx      <= cl_x[OUT_BITS-1:0];
      s6_side_r.cy      <= cl_y[OUT_BITS-1:0];
      s6_adx_r          <= adx_w[OUT_BITS-1:0];
      s6_ady_r          <= ady_w[OUT_BITS-1:0];
    end
  end

  // ---------------- stage 7: squared distance
  logic                  s7_v_r;
  cft_pkg::sqrt_side_t   s7_side_r;
  logic [SQ_W-1:0]       s7_sq_r;
  logic                  sq_rdy [RB+1];
  logic                  sq_v   [RB+1];
  cft_pkg::sqrt_data_t   sq_d   [RB+1];

  assign s7_rdy = !s7_v_r || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (s7_rdy) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s7_rdy && s6_v_r) begin
      s7_side_r <= s6_side_r;
      s7_sq_r   <= SQ_W'(s6_adx_r) * SQ_W'(s6_adx_r) + SQ_W'(s6_ady_r) * SQ_W'(s6_ady_r);
    end
  end

  always_comb begin
    sq_v[0]       = s7_v_r;
    sq_d[0].v     = SR_W'(s7_sq_r);
    sq_d[0].res   = '0;
    sq_d[0].probe = SR_W'(1) << (2 * (RB - 1));
    sq_d[0].side  = s7_side_r;
  end

  // ---------------- root chain, one result bit per cell
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    cft_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[j]),
      .in_ready  (sq_rdy[j]),
      .in_data   (sq_d[j]),
      .out_valid (sq_v[j+1]),
      .out_ready (sq_rdy[j+1]),
      .out_data  (sq_d[j+1])
    );
  end

  // ---------------- output register
  logic                       out_v_r;
  logic                       out_rdy;
  logic signed [OUT_BITS-1:0] out_cx_r, out_cy_r;
  logic [OUT_BITS-1:0]        out_rad_r;
  logic                       out_deg_r, out_sat_r;
  logic                       root_big;
  cft_pkg::sqrt_side_t        fin;

  assign out_rdy      = !out_v_r || out_ch.ready;
  assign sq_rdy[RB]   = out_rdy;
  assign fin          = sq_d[RB].side;
  assign root_big     = sq_d[RB].res[SR_W-1:OUT_BITS] != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= sq_v[RB];
    end
  end

  // degenerate points force zero fields and a clear saturated flag
  always_ff @(posedge clk) begin
    if (out_rdy && sq_v[RB]) begin
      if (fin.deg) begin
        out_cx_r  <= '0;
        out_cy_r  <= '0;
        out_rad_r <= '0;
        out_deg_r <= 1'b1;
        out_sat_r <= 1'b0;
      end else begin
        out_cx_r  <= fin.cx;
        out_cy_r  <= fin.cy;
        out_rad_r <= (fin.rad_big || root_big) ? '1 : sq_d[RB].res[OUT_BITS-1:0];
        out_deg_r <= 1'b0;
        out_sat_r <= fin.sat || root_big;
      end
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.center_x   = out_cx_r;
  assign out_ch.center_y   = out_cy_r;
  assign out_ch.radius     = out_rad_r;
  assign out_ch.degenerate = out_deg_r;
  assign out_ch.saturated  = out_sat_r;

endmodule
